FILE: rtl/core/bba_pkg.sv
// Package with constants, status codes and types of the bitmap block allocator.
`default_nettype none
package bba_pkg;
  localparam int unsigned BLOCKS_DEF = 1024;
  localparam int unsigned FILES_DEF = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned START_W = 10;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic                action;
    logic [KEY_W-1:0]    file_key;
    logic [LEN_W-1:0]    request_length;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_block;
    logic [LEN_W-1:0]    extent_length;
  } rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/bba_req_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface bba_req_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  logic                action;
  logic [KEY_W-1:0]    file_key;
  logic [LEN_W-1:0]    request_length;
  modport source (output valid, action, file_key, request_length, input ready);
  modport sink (input valid, action, file_key, request_length, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_block;
  logic [LEN_W-1:0]    extent_length;
  modport source (output valid, status, start_block, extent_length, input ready);
  modport sink (input valid, status, start_block, extent_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: sequencer, usage map memory and extent table.
//
// Requests arrive on req (valid/ready); each accepted item gives exactly one
// item on rsp. An allocate first scans every entry of the extent table. It then
// scans the usage map one 32-bit word at a time, and bit by bit inside a word
// unless the word is all used, or is all free, lies wholly below the block
// limit and does not complete the run. The run is then marked with a
// read-modify-write of each word it covers. A release scans the table and
// clears its run the same way. Requests are taken one at a time: the next item
// is accepted only after the previous response item has been taken, so a
// stalled receiver holds the response and blocks the input.
// After rst the map is cleared word by word, and no item is accepted during
// this pass; total_blocks resets to 1024. cfg_we writes total_blocks from
// cfg_wdata and is meant only while the block is idle.
`default_nettype none
module bitmap_block_allocator #(
  parameter int unsigned BLOCKS = bba_pkg::BLOCKS_DEF,
  parameter int unsigned FILES  = bba_pkg::FILES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [bba_pkg::LEN_W-1:0] cfg_wdata,
  bba_req_if.sink                       req,
  bba_rsp_if.source                     rsp
);
  import bba_pkg::*;

  localparam int unsigned WORDS = (BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FI_W  = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int unsigned BI_W  = $clog2(WORD_W);
  localparam int unsigned BN_W  = ($clog2(BLOCKS) + 2 > LEN_W + 1) ? $clog2(BLOCKS) + 2
                                                                   : LEN_W + 1;
  localparam int unsigned TE_W  = KEY_W + BN_W + LEN_W;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_TREAD = 11'b00000000100,
    S_TCHK  = 11'b00000001000,
    S_MREAD = 11'b00000010000,
    S_MCHK  = 11'b00000100000,
    S_MBIT  = 11'b00001000000,
    S_WREAD = 11'b00010000000,
    S_WMOD  = 11'b00100000000,
    S_RESP  = 11'b01000000000,
    S_TREL  = 11'b10000000000
  } state_t;

  state_t state;

  logic [WORD_W-1:0] map_mem [WORDS];
  logic [WORD_W-1:0] map_rd;
  logic              map_we;
  logic [WA_W-1:0]   map_wa, map_ra;
  logic [WORD_W-1:0] map_wd;

  logic [TE_W-1:0]   tab_mem [FILES];
  logic [TE_W-1:0]   tab_rd;
  logic              tab_we;
  logic [FI_W-1:0]   tab_wa, tab_ra;
  logic [TE_W-1:0]   tab_wd;
  logic [FILES-1:0]  valid_bits;

  logic [LEN_W-1:0]  total_blocks;
  req_t              cur;
  logic [FI_W:0]     ti;
  logic [FI_W-1:0]   hit_idx, free_idx;
  logic              hit, have_free;
  logic [WA_W:0]     wi;
  logic [BI_W-1:0]   bi;
  logic [BN_W-1:0]   run, start, lim, b_end, bpos;
  logic [WORD_W-1:0] word;
  logic              mark_set;
  logic              out_valid;
  rsp_t              out;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd <= tab_mem[tab_ra];
  end

  assign lim = (BN_W'(total_blocks) > BN_W'(BLOCKS)) ? BN_W'(BLOCKS) : BN_W'(total_blocks);
  assign bpos = BN_W'({wi[WA_W-1:0], bi});
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.status = out.status;
  assign rsp.start_block = out.start_block;
  assign rsp.extent_length = out.extent_length;

  // word mask for blocks [start, b_end) that fall into word wi
  function automatic logic [WORD_W-1:0] range_mask(input logic [BN_W-1:0] s,
      input logic [BN_W-1:0] e, input logic [WA_W:0] w);
    logic [WORD_W-1:0] m;
    logic [BN_W-1:0] p;
    begin
      for (int k = 0; k < WORD_W; k++) begin
        p = BN_W'(w) * BN_W'(WORD_W) + BN_W'(k);
        m[k] = (p >= s) && (p < e);
      end
      return m;
    end
  endfunction

  always_comb begin
    map_we = 1'b0;
    map_wa = wi[WA_W-1:0];
    map_wd = '0;
    map_ra = wi[WA_W-1:0];
    tab_we = 1'b0;
    tab_wa = hit ? hit_idx : free_idx;
    tab_wd = {cur.file_key, start, cur.request_length};
    tab_ra = ti[FI_W-1:0];
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wd = '0;
      end
      S_WMOD: begin
        map_we = 1'b1;
        map_wd = mark_set ? (map_rd | range_mask(start, b_end, wi))
                          : (map_rd & ~range_mask(start, b_end, wi));
      end
      S_RESP: begin
        tab_we = mark_set;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      wi <= '0;
      valid_bits <= '0;
      total_blocks <= LEN_W'(1024);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) total_blocks <= cfg_wdata;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (wi == (WA_W+1)'(WORDS - 1)) begin
            state <= S_IDLE;
          end
          wi <= wi + 1'b1;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= '{action: req.action, file_key: req.file_key,
                     request_length: req.request_length};
            ti <= '0;
            hit <= 1'b0;
            have_free <= 1'b0;
            hit_idx <= '0;
            free_idx <= '0;
            if (req.action == ACT_ALLOC && req.request_length == '0) begin
              out <= '{status: ST_ZERO, start_block: '0, extent_length: '0};
              out_valid <= 1'b1;
            end else begin
              state <= S_TREAD;
            end
          end
        end
        S_TREAD: begin
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (valid_bits[ti[FI_W-1:0]] && tab_rd[TE_W-1 -: KEY_W] == cur.file_key
              && !hit) begin
            hit <= 1'b1;
            hit_idx <= ti[FI_W-1:0];
            start <= tab_rd[LEN_W +: BN_W];
            b_end <= tab_rd[LEN_W +: BN_W] + BN_W'(tab_rd[LEN_W-1:0]);
            out.extent_length <= tab_rd[LEN_W-1:0];
          end
          if (!valid_bits[ti[FI_W-1:0]] && !have_free) begin
            have_free <= 1'b1;
            free_idx <= ti[FI_W-1:0];
          end
          if (ti == (FI_W+1)'(FILES - 1)) begin
            state <= S_TREL;
          end else begin
            ti <= ti + 1'b1;
            state <= S_TREAD;
          end
        end
        S_TREL: begin
          bi <= '0;
          run <= '0;
          if (cur.action == ACT_FREE) begin
            if (!hit) begin
              out <= '{status: ST_NOTFOUND, start_block: '0, extent_length: '0};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              mark_set <= 1'b0;
              if (b_end > BN_W'(BLOCKS)) b_end <= BN_W'(BLOCKS);
              wi <= (WA_W+1)'(start >> BI_W);
              state <= S_WREAD;
            end
          end else if (hit) begin
            out <= '{status: ST_DUP, start_block: '0, extent_length: '0};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (!have_free) begin
            out <= '{status: ST_FULL, start_block: '0, extent_length: '0};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            mark_set <= 1'b1;
            wi <= '0;
            state <= S_MREAD;
          end
        end
        S_MREAD: begin
          if (BN_W'(wi) * BN_W'(WORD_W) >= lim) begin
            out <= '{status: ST_NOSPACE, start_block: '0, extent_length: '0};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MCHK;
          end
        end
        S_MCHK: begin
          word <= map_rd;
          bi <= '0;
          if (map_rd == '1) begin
            run <= '0;
            wi <= wi + 1'b1;
            state <= S_MREAD;
          end else if (map_rd == '0 && BN_W'(wi) * BN_W'(WORD_W) + BN_W'(WORD_W) <= lim
                       && run + BN_W'(WORD_W) < BN_W'(cur.request_length)) begin
            if (run == '0) start <= BN_W'(wi) * BN_W'(WORD_W);
            run <= run + BN_W'(WORD_W);
            wi <= wi + 1'b1;
            state <= S_MREAD;
          end else begin
            state <= S_MBIT;
          end
        end
        S_MBIT: begin
          if (bpos >= lim) begin
            out <= '{status: ST_NOSPACE, start_block: '0, extent_length: '0};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (word[bi]) begin
            run <= '0;
          end else begin
            if (run == '0) start <= bpos;
            run <= run + 1'b1;
            if (run + 1'b1 == BN_W'(cur.request_length)) begin
              b_end <= (run == '0 ? bpos : start) + BN_W'(cur.request_length);
              wi <= (WA_W+1)'((run == '0 ? bpos : start) >> BI_W);
              state <= S_WREAD;
            end
          end
          if (state == S_MBIT && !(bpos >= lim) &&
              !(!word[bi] && run + 1'b1 == BN_W'(cur.request_length))) begin
            if (bi == BI_W'(WORD_W - 1)) begin
              wi <= wi + 1'b1;
              state <= S_MREAD;
            end
            bi <= bi + 1'b1;
          end
        end
        S_WREAD: begin
          state <= S_WMOD;
        end
        S_WMOD: begin
          if (BN_W'(wi) * BN_W'(WORD_W) + BN_W'(WORD_W) >= b_end) begin
            state <= S_RESP;
          end else begin
            wi <= wi + 1'b1;
            state <= S_WREAD;
          end
        end
        S_RESP: begin
          out.status <= ST_OK;
          out.start_block <= START_W'(start);
          if (mark_set) begin
            valid_bits[free_idx] <= 1'b1;
            out.extent_length <= cur.request_length;
          end else begin
            valid_bits[hit_idx] <= 1'b0;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
